// ===== hdl/lrukv_pkg.sv =====
// lrukv_pkg: shared widths, codes and defaults for the LRU key-value cache.
// No dependencies; used by the channel interfaces and the top level.
package lrukv_pkg;

	localparam int ENTRIES_DEF  = 16;
	localparam int KEY_BITS_DEF = 16;

	localparam int KEY_W  = 16;
	localparam int DATA_W = 32;
	localparam int CAP_W  = 5;

	localparam logic [CAP_W-1:0]  CAP_RESET = 5'd10;
	localparam logic [DATA_W-1:0] MISS_WORD = 32'hFFFF_FFFF;

	localparam logic CMD_GET = 1'b0;
	localparam logic CMD_PUT = 1'b1;

endpackage

// ===== hdl/lrukv_if.sv =====
// lrukv_req_if / lrukv_rsp_if: valid/ready channels for requests and results.
// Depends on lrukv_pkg for field widths.
interface lrukv_req_if;
	logic                              valid;
	logic                              ready;
	logic                              cmd;
	logic [lrukv_pkg::KEY_W-1:0]       key;
	logic signed [lrukv_pkg::DATA_W-1:0] value;

	modport source (output valid, output cmd, output key, output value, input ready);
	modport sink   (input valid, input cmd, input key, input value, output ready);
endinterface

interface lrukv_rsp_if;
	logic                              valid;
	logic                              ready;
	logic                              hit;
	logic signed [lrukv_pkg::DATA_W-1:0] read_value;

	modport source (output valid, output hit, output read_value, input ready);
	modport sink   (input valid, input hit, input read_value, output ready);
endinterface

// ===== hdl/lru_key_value_cache_unit.sv =====
// lru_key_value_cache_unit: fully associative key-value store, LRU replacement.
// Requests are accepted only in idle and handled one at a time: a scan sweep over all
// slots, the result, then an update sweep of ranks and the target slot (skipped on a get miss).
// Reset: asynchronous, active low; clears valid bits, fill count, capacity to 10.
// No clearing pass: slot memory is gated by flip-flop valid bits.
// Depends on lrukv_pkg and lrukv_if.
module lru_key_value_cache_unit #(
	parameter int ENTRIES  = lrukv_pkg::ENTRIES_DEF,
	parameter int KEY_BITS = lrukv_pkg::KEY_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	lrukv_req_if.sink                     req,
	lrukv_rsp_if.source                   rsp,
	input  logic                          cfg_we,
	input  logic [lrukv_pkg::CAP_W-1:0]   cfg_wdata
);

	localparam int IDXW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int FILL_W = IDXW + 1;
	localparam int KW     = (KEY_BITS < lrukv_pkg::KEY_W) ? KEY_BITS : lrukv_pkg::KEY_W;
	localparam int CMP_W  = (FILL_W > lrukv_pkg::CAP_W) ? FILL_W : lrukv_pkg::CAP_W;
	localparam int DW     = lrukv_pkg::DATA_W;

	typedef struct packed {
		logic [KW-1:0]   key;
		logic [DW-1:0]   data;
		logic [IDXW-1:0] rank;
	} slot_t;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_RESP = 4'b0100,
		S_UPD  = 4'b1000
	} state_t;

	state_t                        state_q;
	logic [FILL_W-1:0]             cnt_q;
	logic                          chk_vld_q;
	logic [IDXW-1:0]               chk_idx_q;
	logic [ENTRIES-1:0]            valid_q;
	logic [FILL_W-1:0]             fill_q;
	logic [lrukv_pkg::CAP_W-1:0]   cap_q;
	logic                          out_valid_q;

	logic                          cmd_q;
	logic [KW-1:0]                 key_q;
	logic [DW-1:0]                 val_q;

	logic                          found_q, free_q, wv_q;
	logic [IDXW-1:0]               fidx_q, freeidx_q, widx_q;
	logic [IDXW-1:0]               frank_q, wrank_q;
	logic [DW-1:0]                 fdata_q;

	logic [IDXW-1:0]               tgt_q, rref_q;
	logic                          ins_q, newkey_q;
	logic                          hit_q;
	logic [DW-1:0]                 rdval_q;

	slot_t                         mem [ENTRIES];
	slot_t                         rd_q;
	slot_t                         wr_ent;

	logic                          accept, rd_en, last, mem_we, rsp_free, ent_valid;
	logic [IDXW-1:0]               rd_addr;
	logic [lrukv_pkg::CAP_W-1:0]   cap_nz;
	logic                          room;
	logic [IDXW-1:0]               tgt_d, rref_d;
	logic [DW-1:0]                 rdval_d;

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = out_valid_q;
	assign rsp.hit   = hit_q;
	assign rsp.read_value = rdval_q;
	assign rsp_free  = !out_valid_q || rsp.ready;

	assign rd_en   = (state_q == S_SCAN || state_q == S_UPD) && (cnt_q < FILL_W'(ENTRIES));
	assign rd_addr = cnt_q[IDXW-1:0];
	assign last    = chk_vld_q && (chk_idx_q == IDXW'(ENTRIES - 1));
	assign ent_valid = valid_q[chk_idx_q];

	// free slot only while below the effective capacity (zero acts as one)
	assign cap_nz = (cap_q == '0) ? lrukv_pkg::CAP_W'(1) : cap_q;
	assign room   = free_q && (CMP_W'(fill_q) < CMP_W'(cap_nz));

	always_comb begin
		tgt_d  = found_q ? fidx_q : (room ? freeidx_q : widx_q);
		rref_d = found_q ? frank_q : wrank_q;
		if (cmd_q == lrukv_pkg::CMD_GET) begin
			rdval_d = found_q ? fdata_q : lrukv_pkg::MISS_WORD;
		end else begin
			rdval_d = '0;
		end
	end

	// write-back of one slot during the update sweep
	always_comb begin
		wr_ent = rd_q;
		if (chk_idx_q == tgt_q) begin
			wr_ent.rank = '0;
			if (newkey_q) begin
				wr_ent.key = key_q;
			end
			if (cmd_q == lrukv_pkg::CMD_PUT) begin
				wr_ent.data = val_q;
			end
		end else if (ins_q || (rd_q.rank < rref_q)) begin
			wr_ent.rank = rd_q.rank + IDXW'(1);
		end
		mem_we = (state_q == S_UPD) && chk_vld_q && ((chk_idx_q == tgt_q) || ent_valid);
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
		if (mem_we) begin
			mem[chk_idx_q] <= wr_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			chk_vld_q   <= 1'b0;
			valid_q     <= '0;
			fill_q      <= '0;
			cap_q       <= lrukv_pkg::CAP_RESET;
			out_valid_q <= 1'b0;
			found_q     <= 1'b0;
			free_q      <= 1'b0;
			wv_q        <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (state_q == S_RESP && rsp_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			chk_vld_q <= rd_en;
			if (rd_en) begin
				cnt_q <= cnt_q + FILL_W'(1);
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_SCAN;
						cnt_q   <= '0;
						found_q <= 1'b0;
						free_q  <= 1'b0;
						wv_q    <= 1'b0;
					end
				end
				S_SCAN: begin
					if (chk_vld_q) begin
						if (ent_valid && (rd_q.key == key_q) && !found_q) begin
							found_q <= 1'b1;
						end
						if (!ent_valid && !free_q) begin
							free_q <= 1'b1;
						end
						if (ent_valid) begin
							wv_q <= 1'b1;
						end
					end
					if (last) begin
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (rsp_free) begin
						cnt_q <= '0;
						if (cmd_q == lrukv_pkg::CMD_GET && !found_q) begin
							state_q <= S_IDLE;
						end else begin
							state_q <= S_UPD;
						end
						if (cmd_q == lrukv_pkg::CMD_PUT && !found_q && room) begin
							valid_q[freeidx_q] <= 1'b1;
							fill_q             <= fill_q + FILL_W'(1);
						end
					end
				end
				S_UPD: begin
					if (last) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		chk_idx_q <= rd_addr;
		if (accept) begin
			cmd_q <= req.cmd;
			key_q <= req.key[KW-1:0];
			val_q <= req.value;
		end
		if (state_q == S_SCAN && chk_vld_q) begin
			if (ent_valid && (rd_q.key == key_q) && !found_q) begin
				fidx_q  <= chk_idx_q;
				frank_q <= rd_q.rank;
				fdata_q <= rd_q.data;
			end
			if (!ent_valid && !free_q) begin
				freeidx_q <= chk_idx_q;
			end
			if (ent_valid && (!wv_q || (rd_q.rank > wrank_q))) begin
				widx_q  <= chk_idx_q;
				wrank_q <= rd_q.rank;
			end
		end
		if (state_q == S_RESP && rsp_free) begin
			hit_q    <= found_q;
			rdval_q  <= rdval_d;
			tgt_q    <= tgt_d;
			rref_q   <= rref_d;
			ins_q    <= !found_q && room;
			newkey_q <= !found_q;
		end
	end

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(ENTRIES))
		else $error("fill count above entry count");

	a_fill_match: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(fill_q))
		else $error("fill count does not match valid bits");

	a_we_upd: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_UPD))
		else $error("slot write outside update sweep");

	a_rsp_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_RESP))
		else $error("result raised outside response state");

	a_acc_scan: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_SCAN))
		else $error("transfer not followed by scan");
`endif

endmodule
